### rtl/mfd_pkg.sv
// ============================================================================
// Motor feedback frame decoder package
// Shared constants and the decoded frame record passed between stages.
// ============================================================================
`default_nettype none

package mfd_pkg;

    localparam int FRAME_BYTES   = 10;
    localparam int STORED_BYTES  = FRAME_BYTES - 1;
    localparam int IDX_W         = $clog2(FRAME_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_FULL     = IDX_W'(STORED_BYTES);
    localparam logic [IDX_W-1:0] IDX_OVERFLOW = IDX_W'(FRAME_BYTES);

    localparam int POS_W   = 16;
    localparam int DIFF_W  = POS_W + 1;
    localparam int SCALE_W = 19;
    localparam int PROD_W  = DIFF_W + SCALE_W;
    localparam int TDEG_W  = 25;
    localparam int SUM_W   = 50;
    localparam int ANGLE_W = 33;
    localparam int FRAC_DROP = 16;

    localparam logic signed [DIFF_W-1:0]  TURN_JUMP    = 17'sd16384;
    localparam logic signed [SCALE_W-1:0] SCALE_Q24    = 19'sd184326;
    localparam logic signed [TDEG_W-1:0]  DEG_PER_TURN = 25'sd360;

    localparam int OUT_DATA_W = 136;

    typedef struct packed {
        logic        [7:0]  motor_id;
        logic        [7:0]  motor_mode;
        logic signed [15:0] motor_current;
        logic signed [15:0] speed_rpm;
        logic        [15:0] position_raw;
        logic        [7:0]  fault_byte;
        logic        [7:0]  check_byte;
        logic signed [15:0] turn_count;
    } frame_t;

endpackage

`default_nettype wire

### rtl/motor_feedback_frame_decoder.sv
// ============================================================================
// Motor feedback frame decoder
// Decodes 10-byte motor feedback frames into fields, a turn count and an
// absolute angle in Q.8 degrees.
// ============================================================================
// A frame passes the frame register, the multiplier stage, the wide sum stage
// and the output register; the multiplier and wide sum stages set its depth.
// One byte per cycle is taken unless back-pressure holds the receiver.
// Reset clears the byte counter, the turn state, the offset and all valid
// flags; no clearing pass is needed.
`default_nettype none

module motor_feedback_frame_decoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // rx_byte [7:0]
    input  wire logic [7:0]                        s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // motor_id [7:0], motor_mode [15:8], motor_current [31:16],
    // speed_rpm [47:32], position_raw [63:48], fault_byte [71:64],
    // check_byte [79:72], turn_count [95:80], angle_q8 [128:96]
    output logic [mfd_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [15:0]                       cfg_data
);

    logic [15:0]                          offset_reg;
    logic                                 rx_valid;
    logic                                 rx_ready;
    mfd_pkg::frame_t                      rx_frame;
    logic signed [mfd_pkg::DIFF_W-1:0]    rx_diff;
    logic                                 ang_valid;
    logic                                 ang_ready;
    mfd_pkg::frame_t                      ang_frame;
    logic [mfd_pkg::ANGLE_W-1:0]          ang_angle;
    logic                                 out_valid_reg;
    logic [mfd_pkg::OUT_DATA_W-1:0]       out_data_reg;
    logic [mfd_pkg::OUT_DATA_W-1:0]       out_data_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            offset_reg <= cfg_data;
        end
    end

    mfd_frame_rx u_frame_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .offset    (offset_reg),
        .out_valid (rx_valid),
        .out_ready (rx_ready),
        .out_frame (rx_frame),
        .out_diff  (rx_diff)
    );

    mfd_angle u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx_valid),
        .in_ready  (rx_ready),
        .in_frame  (rx_frame),
        .in_diff   (rx_diff),
        .out_valid (ang_valid),
        .out_ready (ang_ready),
        .out_frame (ang_frame),
        .out_angle (ang_angle)
    );

    assign ang_ready = !out_valid_reg || m_axis_tready;

    assign out_data_next = {7'd0,
                            ang_angle,
                            ang_frame.turn_count,
                            ang_frame.check_byte,
                            ang_frame.fault_byte,
                            ang_frame.position_raw,
                            ang_frame.speed_rpm,
                            ang_frame.motor_current,
                            ang_frame.motor_mode,
                            ang_frame.motor_id};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ang_ready)
        begin
            out_valid_reg <= ang_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ang_ready && ang_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A decoded frame only appears after a byte marked last was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rx_valid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("decoded frame without a final byte");

    // A new result word comes from the angle stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(ang_valid))
        else $error("result word without angle data");

    // The angle stages hold their result while the output register is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ang_valid && !ang_ready) |=> ang_valid)
        else $error("angle result dropped under stall");

endmodule

`default_nettype wire

### rtl/mfd_frame_rx.sv
// ============================================================================
// Frame receiver
// Collects frame bytes, checks the frame length, tracks full turns and
// registers one decoded frame for the angle stages.
// ============================================================================
`default_nettype none

module mfd_frame_rx (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        in_byte,
    input  wire logic                              in_last,
    input  wire logic [15:0]                       offset,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output mfd_pkg::frame_t                        out_frame,
    output logic signed [mfd_pkg::DIFF_W-1:0]      out_diff
);

    logic [mfd_pkg::IDX_W-1:0] byte_index_reg;
    logic [mfd_pkg::IDX_W-1:0] byte_index_next;
    logic [7:0]                frame_reg [mfd_pkg::STORED_BYTES];
    logic [15:0]               prev_pos_reg;
    logic signed [15:0]        turns_reg;
    logic signed [15:0]        turns_next;
    logic                      valid_reg;
    logic                      valid_next;
    mfd_pkg::frame_t           frame_out_reg;
    logic signed [mfd_pkg::DIFF_W-1:0] diff_reg;

    logic                      accept;
    logic                      good_end;
    logic [15:0]               pos;
    logic signed [mfd_pkg::DIFF_W-1:0] jump;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign good_end = accept && in_last && (byte_index_reg == mfd_pkg::IDX_FULL);
    assign pos      = {frame_reg[6], frame_reg[7]};
    assign jump     = $signed({1'b0, prev_pos_reg}) - $signed({1'b0, pos});

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (accept)
        begin
            if (in_last)
            begin
                byte_index_next = '0;
            end
            else if (byte_index_reg < mfd_pkg::IDX_FULL)
            begin
                byte_index_next = byte_index_reg + mfd_pkg::IDX_W'(1);
            end
            else
            begin
                byte_index_next = mfd_pkg::IDX_OVERFLOW;
            end
        end
    end

    always_comb
    begin
        turns_next = turns_reg;
        if (jump < -mfd_pkg::TURN_JUMP)
        begin
            turns_next = turns_reg - 16'sd1;
        end
        else if (jump > mfd_pkg::TURN_JUMP)
        begin
            turns_next = turns_reg + 16'sd1;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (good_end)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            prev_pos_reg   <= '0;
            turns_reg      <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            valid_reg      <= valid_next;
            if (good_end)
            begin
                prev_pos_reg <= pos;
                turns_reg    <= turns_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mfd_pkg::STORED_BYTES; i++)
        begin
            if (accept && !in_last && (byte_index_reg == mfd_pkg::IDX_W'(i)))
            begin
                frame_reg[i] <= in_byte;
            end
        end
        if (good_end)
        begin
            frame_out_reg.motor_id      <= frame_reg[0];
            frame_out_reg.motor_mode    <= frame_reg[1];
            frame_out_reg.motor_current <= $signed({frame_reg[2], frame_reg[3]});
            frame_out_reg.speed_rpm     <= $signed({frame_reg[4], frame_reg[5]});
            frame_out_reg.position_raw  <= pos;
            frame_out_reg.fault_byte    <= frame_reg[8];
            frame_out_reg.check_byte    <= in_byte;
            frame_out_reg.turn_count    <= turns_next;
            diff_reg <= $signed({1'b0, pos}) - $signed({1'b0, offset});
        end
    end

    assign out_valid = valid_reg;
    assign out_frame = frame_out_reg;
    assign out_diff  = diff_reg;

endmodule

`default_nettype wire

### rtl/mfd_angle.sv
// ============================================================================
// Angle stages
// Scales the offset position to Q.24 degrees, adds the full turns and
// truncates the sum toward zero to Q.8.
// ============================================================================
`default_nettype none

module mfd_angle (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire mfd_pkg::frame_t                   in_frame,
    input  wire logic signed [mfd_pkg::DIFF_W-1:0] in_diff,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output mfd_pkg::frame_t                        out_frame,
    output logic [mfd_pkg::ANGLE_W-1:0]            out_angle
);

    logic                                 mul_valid_reg;
    logic                                 sum_valid_reg;
    logic                                 mul_ready;
    logic                                 sum_ready;
    mfd_pkg::frame_t                      mul_frame_reg;
    mfd_pkg::frame_t                      sum_frame_reg;
    logic signed [mfd_pkg::PROD_W-1:0]    prod_reg;
    logic signed [mfd_pkg::TDEG_W-1:0]    tdeg_reg;
    logic signed [mfd_pkg::SUM_W-1:0]     sum_reg;
    logic signed [mfd_pkg::SUM_W-1:0]     sum_next;
    logic        [mfd_pkg::SUM_W-1:0]     biased;

    assign sum_ready = !sum_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || sum_ready;
    assign in_ready  = mul_ready;

    assign sum_next = mfd_pkg::SUM_W'(prod_reg)
                    + mfd_pkg::SUM_W'($signed({tdeg_reg, 24'd0}));

    // Adding all ones below the kept bits of a negative sum turns the floor
    // of the shift into truncation toward zero.
    assign biased = sum_reg
                  + {{(mfd_pkg::SUM_W - mfd_pkg::FRAC_DROP){1'b0}},
                     {mfd_pkg::FRAC_DROP{sum_reg[mfd_pkg::SUM_W-1]}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
            begin
                mul_valid_reg <= in_valid;
            end
            if (sum_ready)
            begin
                sum_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_ready && in_valid)
        begin
            mul_frame_reg <= in_frame;
            prod_reg      <= mfd_pkg::PROD_W'(in_diff)
                           * mfd_pkg::PROD_W'(mfd_pkg::SCALE_Q24);
            tdeg_reg      <= mfd_pkg::TDEG_W'(in_frame.turn_count) * mfd_pkg::DEG_PER_TURN;
        end
        if (sum_ready && mul_valid_reg)
        begin
            sum_frame_reg <= mul_frame_reg;
            sum_reg       <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_frame = sum_frame_reg;
    assign out_angle = biased[mfd_pkg::FRAC_DROP + mfd_pkg::ANGLE_W - 1:mfd_pkg::FRAC_DROP];

endmodule

`default_nettype wire
